[hw/rtl/xlg_pkg.sv]
package xlg_pkg;

	// default sizes
	localparam int LANES_DEF    = 8;
	localparam int MAX_DRAW_DEF = 64;

	// splitmix64 constants
	localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_B  = 64'h94d049bb133111eb;
	localparam int SH_MIX1 = 30;
	localparam int SH_MIX2 = 27;
	localparam int SH_MIX3 = 31;

	// xoroshiro128++ rotations and shifts
	localparam int ROT_OUT = 17;
	localparam int ROT_LO  = 49;
	localparam int SH_LO   = 21;
	localparam int ROT_HI  = 28;

	// fraction numerator is value >> 11
	localparam int FRAC_SHIFT = 11;

	// request kinds
	localparam logic REQ_RESTART = 1'b0;
	localparam logic REQ_DRAW    = 1'b1;

	// commands from the sequencer to the lane bank
	typedef struct packed {
		logic wr_lo;
		logic wr_hi;
		logic step;
	} lane_cmd_t;

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_LO_GO   = 6'b000010,
		ST_LO_WAIT = 6'b000100,
		ST_HI_GO   = 6'b001000,
		ST_HI_WAIT = 6'b010000,
		ST_DRAW    = 6'b100000
	} seq_state_t;

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int r);
		return (v << r) | (v >> (64 - r));
	endfunction

	// xoroshiro128++ output word
	function automatic logic [63:0] xo_output(input logic [63:0] a, input logic [63:0] b);
		return rotl64(a + b, ROT_OUT) + a;
	endfunction

endpackage

[hw/rtl/xlg_ifs.sv]
// request channel: kind and draw count
interface xlg_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [6:0] count;

	modport source (output valid, req_type, count, input ready);
	modport sink (input valid, req_type, count, output ready);
endinterface

// result channel: one drawn value
interface xlg_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [52:0] fraction53;
	logic        last;

	modport source (output valid, value, fraction53, last, input ready);
	modport sink (input valid, value, fraction53, last, output ready);
endinterface

[hw/rtl/xlg_mix.sv]
// splitmix64 finalizer on one shared 32x32 multiplier
// each 64-bit product sums the lo*lo, lo*hi and hi*lo partial products, then a fold step applies the xor-shift
module xlg_mix import xlg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [63:0] result
);

	logic [63:0] op_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;
	logic [1:0]  step_q;
	logic        pass_q;
	logic        busy_q;
	logic        done_q;

	logic [63:0] z;
	logic [63:0] pre;
	logic [63:0] k;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic        launch;

	assign launch = start && !busy_q;
	assign z      = x + GOLDEN;
	assign pre    = z ^ (z >> SH_MIX1);
	assign k      = pass_q ? MIX_B : MIX_A;

	// partial product select: lo*lo, lo*hi, hi*lo
	always_comb begin
		case (step_q)
			2'd0: begin
				mul_a = op_q[31:0];
				mul_b = k[31:0];
			end
			2'd1: begin
				mul_a = op_q[31:0];
				mul_b = k[63:32];
			end
			default: begin
				mul_a = op_q[63:32];
				mul_b = k[31:0];
			end
		endcase
	end

	assign prod = {32'b0, mul_a} * {32'b0, mul_b};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			pass_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
				pass_q <= 1'b0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					if (!pass_q) begin
						pass_q <= 1'b1;
					end else begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (launch) begin
			op_q <= pre;
		end else if (busy_q) begin
			case (step_q) inside
				2'd0: acc_q <= prod;
				2'd1, 2'd2: acc_q <= acc_q + {prod[31:0], 32'b0};
				default: begin
					if (!pass_q)
						op_q <= acc_q ^ (acc_q >> SH_MIX2);
					else
						res_q <= acc_q ^ (acc_q >> SH_MIX3);
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

[hw/rtl/xlg_lanes.sv]
// generator state of all lanes; one lane read, stepped or written per cycle
module xlg_lanes import xlg_pkg::*; #(
	parameter int LANES = LANES_DEF,
	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1
) (
	input  logic              clk,
	input  lane_cmd_t         cmd,
	input  logic [LANE_W-1:0] idx,
	input  logic [63:0]       wdata,
	output logic [63:0]       value
);

	logic [63:0] lo_q [LANES];
	logic [63:0] hi_q [LANES];

	logic [63:0] a;
	logic [63:0] b;
	logic [63:0] bx;
	logic [63:0] next_lo;
	logic [63:0] next_hi;

	assign a       = lo_q[idx];
	assign b       = hi_q[idx];
	assign value   = xo_output(a, b);
	assign bx      = a ^ b;
	assign next_lo = rotl64(a, ROT_LO) ^ bx ^ (bx << SH_LO);
	assign next_hi = rotl64(bx, ROT_HI);

	// seeding writes and generator steps
	always_ff @(posedge clk) begin
		if (cmd.wr_lo)
			lo_q[idx] <= wdata;
		if (cmd.wr_hi)
			hi_q[idx] <= wdata;
		if (cmd.step) begin
			lo_q[idx] <= next_lo;
			hi_q[idx] <= next_hi;
		end
	end

endmodule

[hw/rtl/eight_lane_xoroshiro_generator.sv]
// channel  | dir | payload                          | handshake
// ---------+-----+----------------------------------+-------------------
// req      | in  | req_type, count                  | valid / ready
// res      | out | value, fraction53, last          | valid / ready
// cfg      | in  | cfg_wdata (seed)                 | cfg_we, no stall
//
// A draw of n values sends one value a cycle from the lane bank while res is not
// stalled, one lane stepped per value.
// A restart reseeds lane by lane through the shared splitmix unit, two mixes per
// lane (lo word, then hi word); req.ready is low meanwhile. The same seeding pass
// runs after arst_n with seed 0.
// A stall on res holds the current value and pauses the draw.
module eight_lane_xoroshiro_generator import xlg_pkg::*; #(
	parameter int LANES    = LANES_DEF,
	parameter int MAX_DRAW = MAX_DRAW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	xlg_req_if.sink     req,
	xlg_res_if.source   res
);

	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int IDX_W  = $clog2(LANES + 1);

	seq_state_t        state_q;
	logic [63:0]       seed_q;
	logic [LANE_W-1:0] lane_q;
	logic [IDX_W-1:0]  idx_q;
	logic [6:0]        rem_q;
	logic              res_valid_q;
	logic [63:0]       res_value_q;
	logic              res_last_q;

	logic              req_acc;
	logic [6:0]        count_sat;
	logic [LANE_W-1:0] pos;
	logic              load;
	logic              last_lane;
	logic              mix_start;
	logic [63:0]       mix_x;
	logic              mix_done;
	logic [63:0]       mix_res;
	lane_cmd_t         lane_cmd;
	logic [LANE_W-1:0] lane_idx;
	logic [63:0]       lane_value;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign count_sat = (req.count > 7'(MAX_DRAW)) ? 7'(MAX_DRAW) : req.count;

	// buffer position: wraps to lane 0 when the buffer is used up
	assign pos  = (idx_q >= IDX_W'(LANES)) ? '0 : idx_q[LANE_W-1:0];
	assign load = (state_q == ST_DRAW) && (!res_valid_q || res.ready);

	assign last_lane = (lane_q == LANE_W'(LANES - 1));

	// seeding mixes
	assign mix_start = (state_q == ST_LO_GO) || (state_q == ST_HI_GO);
	assign mix_x     = (state_q == ST_LO_GO) ? seed_q + 64'(lane_q) : mix_res;

	xlg_mix u_mix (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mix_start),
		.x      (mix_x),
		.done   (mix_done),
		.result (mix_res)
	);

	// lane bank commands
	assign lane_cmd.wr_lo = (state_q == ST_LO_WAIT) && mix_done;
	assign lane_cmd.wr_hi = (state_q == ST_HI_WAIT) && mix_done;
	assign lane_cmd.step  = load;
	assign lane_idx       = (state_q == ST_DRAW) ? pos : lane_q;

	xlg_lanes #(
		.LANES (LANES)
	) u_lanes (
		.clk   (clk),
		.cmd   (lane_cmd),
		.idx   (lane_idx),
		.wdata (mix_res),
		.value (lane_value)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LO_GO;
			seed_q  <= 64'd0;
			lane_q  <= '0;
			idx_q   <= IDX_W'(LANES);
			rem_q   <= 7'd0;
		end else begin
			if (cfg_we)
				seed_q <= cfg_wdata;
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						if (req.req_type == REQ_RESTART) begin
							state_q <= ST_LO_GO;
							lane_q  <= '0;
							idx_q   <= IDX_W'(LANES);
						end else if (count_sat != 7'd0) begin
							rem_q   <= count_sat;
							state_q <= ST_DRAW;
						end
					end
				end
				ST_LO_GO: state_q <= ST_LO_WAIT;
				ST_LO_WAIT: begin
					if (mix_done)
						state_q <= ST_HI_GO;
				end
				ST_HI_GO: state_q <= ST_HI_WAIT;
				ST_HI_WAIT: begin
					if (mix_done) begin
						if (last_lane) begin
							state_q <= ST_IDLE;
						end else begin
							lane_q  <= lane_q + LANE_W'(1);
							state_q <= ST_LO_GO;
						end
					end
				end
				ST_DRAW: begin
					if (load) begin
						idx_q <= IDX_W'(pos) + IDX_W'(1);
						rem_q <= rem_q - 7'd1;
						if (rem_q == 7'd1)
							state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (load)
			res_valid_q <= 1'b1;
		else if (res.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_value_q <= lane_value;
			res_last_q  <= (rem_q == 7'd1);
		end
	end

	assign res.valid      = res_valid_q;
	assign res.value      = res_value_q;
	assign res.fraction53 = res_value_q[63:FRAC_SHIFT];
	assign res.last       = res_last_q;

endmodule

[hw/rtl/xlg_checker.sv]
// port-level checks for the generator
module xlg_checker import xlg_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        req_type,
	input logic [6:0]  req_count,
	input logic        res_valid,
	input logic        res_ready,
	input logic [63:0] res_value,
	input logic [52:0] res_fraction53
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_value))
		else $error("result changed while stalled");

	// fraction is the top bits of the value
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_fraction53 == res_value[63:FRAC_SHIFT])
		else $error("fraction53 does not match value");

	// a restart request keeps the block busy while it reseeds
	a_restart_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == REQ_RESTART |=> !req_ready)
		else $error("ready during reseed");

	// a nonempty draw request keeps the block busy
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == REQ_DRAW && req_count != 7'd0
		|=> !req_ready)
		else $error("ready during draw");

endmodule

bind eight_lane_xoroshiro_generator xlg_checker u_xlg_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.req_type       (req.req_type),
	.req_count      (req.count),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_value      (res.value),
	.res_fraction53 (res.fraction53)
);
